// ----- sv/text_line_filter_core_macros.svh -----
// Assertion macros for the text line filter checker.
// Used by tlf_checker only; no other dependencies.
`ifndef TEXT_LINE_FILTER_CORE_MACROS_SVH
`define TEXT_LINE_FILTER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define TLF_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define TLF_ASSERT_NXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ----- sv/tlf_pkg.sv -----
// Shared types and constants of the text line filter.
// No dependencies; imported by every module of the block.
package tlf_pkg;

	localparam int TLF_NUMBER_DIGITS = 6;
	localparam int CFG_ADDR_W        = 5;

	// Register indexes (byte address / 4)
	localparam logic [2:0] REG_NUMBER_ALL       = 3'd0;
	localparam logic [2:0] REG_NUMBER_NONBLANK  = 3'd1;
	localparam logic [2:0] REG_SQUEEZE_BLANK    = 3'd2;
	localparam logic [2:0] REG_SHOW_ENDS        = 3'd3;
	localparam logic [2:0] REG_SHOW_TABS        = 3'd4;
	localparam logic [2:0] REG_SHOW_NONPRINTING = 3'd5;

	// Character codes
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_NL       = 8'h0A;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_CARET    = 8'h5E;
	localparam logic [7:0] CH_I        = 8'h49;
	localparam logic [7:0] CH_DOLLAR   = 8'h24;
	localparam logic [7:0] CH_QMARK    = 8'h3F;
	localparam logic [7:0] CH_DEL      = 8'd127;
	localparam logic [7:0] CTRL_OFFSET = 8'd64;
	localparam logic [7:0] CTRL_LOW_END  = 8'd8;
	localparam logic [7:0] CTRL_HIGH_BEG = 8'd11;
	localparam logic [7:0] CTRL_HIGH_END = 8'd31;

	typedef struct packed {
		logic number_all;
		logic number_nonblank;
		logic squeeze_blank;
		logic show_ends;
		logic show_tabs;
		logic show_nonprinting;
	} tlf_cfg_t;

	// Expansion of one input byte, apart from the number characters
	typedef struct packed {
		logic       num;
		logic       pre;
		logic [7:0] pre_byte;
		logic [7:0] main_byte;
		logic       nothing;
	} tlf_exp_t;

endpackage

// ----- sv/tlf_cfg.sv -----
// APB-style mode register file of the text line filter.
// Depends on tlf_pkg for register indexes and the mode struct.
module tlf_cfg import tlf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	output tlf_cfg_t              cfg
);

	tlf_cfg_t   cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[4:2];
	assign cfg    = cfg_q;

	// Write one mode bit per request; ignore indexes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_NUMBER_ALL:       cfg_q.number_all       <= pwdata[0];
				REG_NUMBER_NONBLANK:  cfg_q.number_nonblank  <= pwdata[0];
				REG_SQUEEZE_BLANK:    cfg_q.squeeze_blank    <= pwdata[0];
				REG_SHOW_ENDS:        cfg_q.show_ends        <= pwdata[0];
				REG_SHOW_TABS:        cfg_q.show_tabs        <= pwdata[0];
				REG_SHOW_NONPRINTING: cfg_q.show_nonprinting <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read back the addressed mode bit
	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_NUMBER_ALL:       prdata[0] = cfg_q.number_all;
			REG_NUMBER_NONBLANK:  prdata[0] = cfg_q.number_nonblank;
			REG_SQUEEZE_BLANK:    prdata[0] = cfg_q.squeeze_blank;
			REG_SHOW_ENDS:        prdata[0] = cfg_q.show_ends;
			REG_SHOW_TABS:        prdata[0] = cfg_q.show_tabs;
			REG_SHOW_NONPRINTING: prdata[0] = cfg_q.show_nonprinting;
			default:              prdata    = '0;
		endcase
	end

endmodule

// ----- sv/tlf_expand.sv -----
// Line state and single-pass rewrite of one input byte into its result list.
// Depends on tlf_pkg for character codes, the mode struct and the expansion struct.
module tlf_expand import tlf_pkg::*; #(
	parameter int NUMBER_DIGITS = TLF_NUMBER_DIGITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic [7:0]                 data_byte,
	input  logic                       file_start,
	input  tlf_cfg_t                   cfg,
	output tlf_exp_t                   exp,
	output logic [8*NUMBER_DIGITS-1:0] chars
);

	localparam int BCD_W = 4 * NUMBER_DIGITS;

	logic [BCD_W-1:0] bcd_q;
	logic             at_start_q;
	logic [1:0]       run_q;

	logic [BCD_W-1:0] bcd_eff;
	logic [BCD_W-1:0] bcd_inc;
	logic [BCD_W-1:0] bcd_nxt;
	logic             at_start_eff;
	logic [1:0]       run_eff;
	logic [1:0]       run_nxt;
	logic             visible;
	logic             is_nl;
	logic             is_ctrl;

	// Apply the file-start mark before the byte is handled
	assign bcd_eff      = file_start ? BCD_W'(1) : bcd_q;
	assign at_start_eff = file_start | at_start_q;
	assign run_eff      = file_start ? 2'd1 : run_q;
	assign is_nl        = (data_byte == CH_NL);
	assign is_ctrl      = (data_byte <= CTRL_LOW_END) ||
	                      (data_byte >= CTRL_HIGH_BEG && data_byte <= CTRL_HIGH_END);

	// Count newline runs (the start counts as one); the third and later are squeezed
	always_comb begin
		if (cfg.squeeze_blank && is_nl) begin
			run_nxt = (run_eff == 2'd3) ? 2'd3 : run_eff + 2'd1;
		end else begin
			run_nxt = 2'd0;
		end
	end
	assign visible = (run_nxt != 2'd3);

	// Decide numbering, caret or dollar prefix, and the main byte
	always_comb begin
		exp.num = at_start_eff &&
		          ((cfg.number_nonblank && !is_nl) ||
		           (!cfg.number_nonblank && cfg.number_all && visible));
		exp.pre       = 1'b0;
		exp.pre_byte  = CH_CARET;
		exp.main_byte = data_byte;
		exp.nothing   = 1'b0;
		if (cfg.show_tabs && data_byte == CH_TAB) begin
			exp.pre       = 1'b1;
			exp.main_byte = CH_I;
		end else if (cfg.show_nonprinting && is_ctrl) begin
			exp.pre       = 1'b1;
			exp.main_byte = data_byte + CTRL_OFFSET;
		end else if (cfg.show_nonprinting && data_byte == CH_DEL) begin
			exp.pre       = 1'b1;
			exp.main_byte = CH_QMARK;
		end else if (cfg.show_ends && is_nl && visible) begin
			exp.pre      = 1'b1;
			exp.pre_byte = CH_DOLLAR;
		end
		if (!visible) begin
			exp.main_byte = 8'd0;
			exp.nothing   = 1'b1;
		end
	end

	// Format the line number: leading zeros as spaces, digits clamped to 9
	always_comb begin
		logic       leading;
		logic [3:0] digit;
		leading = 1'b1;
		chars   = '0;
		for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
			digit = bcd_eff[4*i +: 4];
			if (digit > 4'd9) begin
				digit = 4'd9;
			end
			if (digit == 4'd0 && leading && i > 0) begin
				chars[8*i +: 8] = CH_SPACE;
			end else begin
				leading         = 1'b0;
				chars[8*i +: 8] = CH_ZERO + {4'd0, digit};
			end
		end
	end

	// Saturating BCD increment: hold at all nines
	always_comb begin
		logic       carry;
		logic       all_nines;
		logic [3:0] digit;
		carry     = 1'b1;
		all_nines = 1'b1;
		bcd_inc   = bcd_eff;
		for (int i = 0; i < NUMBER_DIGITS; i++) begin
			if (bcd_eff[4*i +: 4] != 4'd9) begin
				all_nines = 1'b0;
			end
		end
		for (int i = 0; i < NUMBER_DIGITS; i++) begin
			digit = bcd_eff[4*i +: 4];
			if (carry) begin
				if (digit >= 4'd9) begin
					bcd_inc[4*i +: 4] = 4'd0;
				end else begin
					bcd_inc[4*i +: 4] = digit + 4'd1;
					carry             = 1'b0;
				end
			end
		end
		if (all_nines) begin
			bcd_inc = bcd_eff;
		end
	end
	assign bcd_nxt = exp.num ? bcd_inc : bcd_eff;

	// Advance line state on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcd_q      <= BCD_W'(1);
			at_start_q <= 1'b1;
			run_q      <= 2'd1;
		end else if (accept) begin
			bcd_q      <= bcd_nxt;
			at_start_q <= is_nl | (at_start_eff & ~exp.num);
			run_q      <= run_nxt;
		end
	end

endmodule

// ----- sv/tlf_emit.sv -----
// Result register and byte sequencer: sends one result byte per cycle while out_ready is high.
// Depends on tlf_pkg for character codes and the expansion struct.
module tlf_emit import tlf_pkg::*; #(
	parameter int NUMBER_DIGITS = TLF_NUMBER_DIGITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load_valid,
	output logic                       load_ready,
	input  tlf_exp_t                   exp,
	input  logic [8*NUMBER_DIGITS-1:0] chars,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [7:0]                 out_byte,
	output logic                       last_of_run,
	output logic                       nothing_out
);

	localparam int SLOT_W = $clog2(NUMBER_DIGITS + 3);
	localparam logic [SLOT_W-1:0] SLOT_TAB  = SLOT_W'(NUMBER_DIGITS);
	localparam logic [SLOT_W-1:0] SLOT_PRE  = SLOT_W'(NUMBER_DIGITS + 1);
	localparam logic [SLOT_W-1:0] SLOT_MAIN = SLOT_W'(NUMBER_DIGITS + 2);

	logic                       valid_q;
	logic [SLOT_W-1:0]          slot_q;
	logic                       pre_q;
	logic [7:0]                 pre_byte_q;
	logic [7:0]                 main_byte_q;
	logic                       nothing_q;
	logic [8*NUMBER_DIGITS-1:0] chars_q;

	logic                       done;
	logic                       load;
	logic [SLOT_W-1:0]          slot_start;
	logic [SLOT_W-1:0]          slot_nxt;

	assign done       = valid_q && out_ready && (slot_q == SLOT_MAIN);
	assign load_ready = !valid_q || done;
	assign load       = load_valid && load_ready;
	assign slot_start = exp.num ? '0 : (exp.pre ? SLOT_PRE : SLOT_MAIN);

	// Step through digits, tab, prefix and main byte, skipping empty slots
	always_comb begin
		if (slot_q == SLOT_TAB) begin
			slot_nxt = pre_q ? SLOT_PRE : SLOT_MAIN;
		end else if (slot_q == SLOT_PRE) begin
			slot_nxt = SLOT_MAIN;
		end else begin
			slot_nxt = slot_q + SLOT_W'(1);
		end
	end

	// Hold the current request until its last byte is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			slot_q  <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			slot_q  <= slot_start;
		end else if (done) begin
			valid_q <= 1'b0;
		end else if (valid_q && out_ready) begin
			slot_q <= slot_nxt;
		end
	end

	// Capture the expansion payload
	always_ff @(posedge clk) begin
		if (load) begin
			pre_q       <= exp.pre;
			pre_byte_q  <= exp.pre_byte;
			main_byte_q <= exp.main_byte;
			nothing_q   <= exp.nothing;
			chars_q     <= chars;
		end
	end

	// Select the byte for the current slot; slot 0 is the top digit
	always_comb begin
		out_byte = main_byte_q;
		if (slot_q == SLOT_TAB) begin
			out_byte = CH_TAB;
		end else if (slot_q == SLOT_PRE) begin
			out_byte = pre_byte_q;
		end
		for (int i = 0; i < NUMBER_DIGITS; i++) begin
			if (slot_q == SLOT_W'(i)) begin
				out_byte = chars_q[8*(NUMBER_DIGITS-1-i) +: 8];
			end
		end
	end

	assign out_valid   = valid_q;
	assign last_of_run = (slot_q == SLOT_MAIN);
	assign nothing_out = nothing_q;

endmodule

// ----- sv/text_line_filter_core.sv -----
// Top level of the text line filter: mode registers, rewrite stage and result sequencer.
// Depends on tlf_pkg, tlf_cfg, tlf_expand and tlf_emit.

// Rewrites a byte stream the way cat does with -n, -b, -s, -E, -T and -v. Each input byte
// becomes one to NUMBER_DIGITS+3 result bytes on the master stream, one byte per cycle
// while m_tready is high; tlast marks the final byte of each input's results and tuser
// flags a squeezed newline (one result, data zero). An input byte is taken in the cycle
// its predecessor's last result is taken, or at once when the result register is empty,
// so plain bytes flow at one per cycle while m_tready is high; the output port alone
// sets throughput. The first result shows in the cycle after the input is accepted. The
// line counter is BCD and stops at all nines; tuser on the input restarts
// the counter and line state before that byte is handled. Mode registers sit at byte
// addresses 0, 4, ..., 20 in the order number_all, number_nonblank, squeeze_blank,
// show_ends, show_tabs, show_nonprinting; write them only while the stream is idle.
module text_line_filter_core import tlf_pkg::*; #(
	parameter int NUMBER_DIGITS = TLF_NUMBER_DIGITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	// input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [7:0] data_byte
	input  logic [0:0]            s_tuser,   // [0] file_start
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,   // [7:0] out_byte
	output logic                  m_tlast,   // last_of_run
	output logic [0:0]            m_tuser    // [0] nothing_out
);

	tlf_cfg_t                   cfg;
	tlf_exp_t                   exp;
	logic [8*NUMBER_DIGITS-1:0] chars;
	logic                       accept;

	assign accept = s_tvalid && s_tready;

	tlf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tlf_expand #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_expand (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.data_byte  (s_tdata),
		.file_start (s_tuser[0]),
		.cfg        (cfg),
		.exp        (exp),
		.chars      (chars)
	);

	tlf_emit #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.load_valid  (s_tvalid),
		.load_ready  (s_tready),
		.exp         (exp),
		.chars       (chars),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_byte    (m_tdata),
		.last_of_run (m_tlast),
		.nothing_out (m_tuser[0])
	);

endmodule

// ----- sv/tlf_checker.sv -----
// Port-level checks of the text line filter, bound to its top level.
// Depends on text_line_filter_core_macros.svh.
`include "text_line_filter_core_macros.svh"

module tlf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast,
	input logic [0:0] m_tuser
);

	// A stalled result holds its bytes
	`TLF_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "stalled result changed")

	// Every accepted request shows a result in the next cycle
	`TLF_ASSERT_NXT(a_accept_result, clk, arst_n, s_tvalid && s_tready, m_tvalid, "accepted request produced no result")

	// No new request while a result run is still in progress
	`TLF_ASSERT_IMP(a_no_overlap, clk, arst_n, m_tvalid && !m_tlast, !s_tready, "request taken mid run")

	// A squeezed newline is a single zero result
	`TLF_ASSERT_IMP(a_squeeze_single, clk, arst_n, m_tvalid && m_tuser[0], m_tlast && (m_tdata == 8'd0), "squeezed result malformed")

endmodule

bind text_line_filter_core tlf_checker u_tlf_checker (.*);
